// ----- hw/rtl/scl_pkg.sv -----
// ----------------------------------------------------------------------------
// scl_pkg
// shared constants and controller/datapath interface types for the slot cache
// ----------------------------------------------------------------------------
package scl_pkg;

  localparam int unsigned CACHE_ENTRIES = 64;
  localparam int unsigned IDX_W         = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
  localparam int unsigned CNT_W         = IDX_W + 1;

  localparam int unsigned KEY_W   = 16;
  localparam int unsigned STAMP_W = 32;
  localparam int unsigned OUT_IDX_W = 6;
  localparam int unsigned WORD_W  = 2 * KEY_W + STAMP_W;

  // controller to datapath
  typedef struct packed {
    logic load;   // capture query and clear the scan trackers
    logic scan;   // walk the entry memory
    logic write;  // commit the chosen entry and load the result register
  } scl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_done;
  } scl_stat_t;

endpackage

// ----- hw/rtl/scl_ctrl.sv -----
// ----------------------------------------------------------------------------
// scl_ctrl
// sequencer for one lookup: capture, memory walk, commit, result handshake
// ----------------------------------------------------------------------------
module scl_ctrl import scl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  input  scl_stat_t stat_i,
  output scl_cmd_t  cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_WRITE = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd_o.scan = 1'b1;
        if (stat_i.scan_done) begin
          state_d = ST_WRITE;
        end
      end
      ST_WRITE: begin
        // hold until the result register is free
        if (!out_valid_q || out_ready_i) begin
          cmd_o.write = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.write) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ----- hw/rtl/scl_dpath.sv -----
// ----------------------------------------------------------------------------
// scl_dpath
// entry memory, valid bits, walk counter, hit/free/oldest trackers and result
// ----------------------------------------------------------------------------
module scl_dpath import scl_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  scl_cmd_t             cmd_i,
  output scl_stat_t            stat_o,
  input  logic signed [15:0]   slot_x_i,
  input  logic signed [15:0]   slot_z_i,
  input  logic [31:0]          frame_number_i,
  output logic [OUT_IDX_W-1:0] entry_index_o,
  output logic                 hit_o,
  output logic                 victim_was_valid_o
);

  // entry word: key x, key z, use stamp
  logic [WORD_W-1:0] mem_q [CACHE_ENTRIES];
  logic [CACHE_ENTRIES-1:0] valid_q;

  logic [KEY_W-1:0]   qx_q, qz_q;
  logic [STAMP_W-1:0] frame_q;

  logic [CNT_W-1:0]  cnt_q;
  logic              pend_q;
  logic [WORD_W-1:0] rd_data_q;
  logic              rd_valid_q;
  logic [IDX_W-1:0]  rd_idx_q;

  logic               found_q, have_free_q, have_oldest_q;
  logic [IDX_W-1:0]   hit_idx_q, free_idx_q, oldest_idx_q;
  logic [STAMP_W-1:0] oldest_stamp_q;

  logic [OUT_IDX_W-1:0] entry_index_q;
  logic                 hit_q, victim_valid_q;

  logic               cnt_end;
  logic [IDX_W-1:0]   rd_addr;
  logic [KEY_W-1:0]   rd_x, rd_z;
  logic [STAMP_W-1:0] rd_stamp;
  logic [IDX_W-1:0]   chosen;
  logic               evict;

  assign cnt_end  = (cnt_q == CNT_W'(CACHE_ENTRIES));
  assign rd_addr  = cnt_q[IDX_W-1:0];
  assign rd_x     = rd_data_q[WORD_W-1 -: KEY_W];
  assign rd_z     = rd_data_q[STAMP_W +: KEY_W];
  assign rd_stamp = rd_data_q[STAMP_W-1:0];

  assign stat_o.scan_done = cnt_end && pend_q;

  assign evict  = !found_q && !have_free_q;
  assign chosen = found_q ? hit_idx_q : (have_free_q ? free_idx_q : oldest_idx_q);

  // entry memory: one read port for the walk, one write port for the commit
  always_ff @(posedge clk_i) begin
    if (cmd_i.scan && !cnt_end) begin
      rd_data_q <= mem_q[rd_addr];
    end
    if (cmd_i.write) begin
      mem_q[chosen] <= {qx_q, qz_q, frame_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (cmd_i.write) begin
      valid_q[chosen] <= 1'b1;
    end
  end

  // walk control and trackers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q         <= '0;
      pend_q        <= 1'b0;
      found_q       <= 1'b0;
      have_free_q   <= 1'b0;
      have_oldest_q <= 1'b0;
    end else if (cmd_i.load) begin
      cnt_q         <= '0;
      pend_q        <= 1'b0;
      found_q       <= 1'b0;
      have_free_q   <= 1'b0;
      have_oldest_q <= 1'b0;
    end else if (cmd_i.scan) begin
      if (!cnt_end) begin
        cnt_q  <= cnt_q + CNT_W'(1);
        pend_q <= 1'b1;
      end else begin
        pend_q <= 1'b0;
      end
      if (pend_q) begin
        if (rd_valid_q) begin
          if (!found_q && rd_x == qx_q && rd_z == qz_q) begin
            found_q <= 1'b1;
          end
          if (!have_oldest_q || rd_stamp < oldest_stamp_q) begin
            have_oldest_q <= 1'b1;
          end
        end else if (!have_free_q) begin
          have_free_q <= 1'b1;
        end
      end
    end
  end

  // payload side of the walk, no reset needed
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      qx_q    <= slot_x_i;
      qz_q    <= slot_z_i;
      frame_q <= frame_number_i;
    end
    if (cmd_i.scan && !cnt_end) begin
      rd_valid_q <= valid_q[rd_addr];
      rd_idx_q   <= rd_addr;
    end
    if (cmd_i.scan && pend_q) begin
      if (rd_valid_q) begin
        if (!found_q && rd_x == qx_q && rd_z == qz_q) begin
          hit_idx_q <= rd_idx_q;
        end
        // strict compare keeps the lowest index on equal stamps
        if (!have_oldest_q || rd_stamp < oldest_stamp_q) begin
          oldest_idx_q   <= rd_idx_q;
          oldest_stamp_q <= rd_stamp;
        end
      end else if (!have_free_q) begin
        free_idx_q <= rd_idx_q;
      end
    end
    if (cmd_i.write) begin
      entry_index_q  <= OUT_IDX_W'(chosen);
      hit_q          <= found_q;
      victim_valid_q <= evict;
    end
  end

  assign entry_index_o      = entry_index_q;
  assign hit_o              = hit_q;
  assign victim_was_valid_o = victim_valid_q;

endmodule

// ----- hw/rtl/slot_cache_lru_lookup.sv -----
// ----------------------------------------------------------------------------
// slot_cache_lru_lookup
// one item at a time: a new item is accepted only after the last one is committed;
// the rate is set by the walk over the single-read-port entry memory, one entry per
//   cycle, and the commit waits while an unread result is still held
// reset: valid bits clear at once, no clearing pass; keys and stamps unset
// fully associative slot cache, hit lookup with lru replacement by stamp
// ----------------------------------------------------------------------------
module slot_cache_lru_lookup import scl_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic signed [15:0]   slot_x_i,
  input  logic signed [15:0]   slot_z_i,
  input  logic [31:0]          frame_number_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [OUT_IDX_W-1:0] entry_index_o,
  output logic                 hit_o,
  output logic                 victim_was_valid_o
);

  scl_cmd_t  cmd;
  scl_stat_t stat;

  scl_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  scl_dpath u_dpath (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .stat_o             (stat),
    .slot_x_i           (slot_x_i),
    .slot_z_i           (slot_z_i),
    .frame_number_i     (frame_number_i),
    .entry_index_o      (entry_index_o),
    .hit_o              (hit_o),
    .victim_was_valid_o (victim_was_valid_o)
  );

endmodule

// ----- verif/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench for slot_cache_lru_lookup
// sends slot queries with bursty input and a stalling output, predicts the
// entry index, hit and eviction flag of every item and checks them in order
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import scl_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned DRAIN_CYCLES   = 100;
  localparam int unsigned HOLD_OFF_LEN   = 800;
  localparam int unsigned KEY_POOL       = 96;
  localparam int unsigned HOT_KEYS       = 40;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_RANDOM,
    READY_PATTERN
  } ready_mode_e;

  typedef struct packed {
    logic [OUT_IDX_W-1:0] entry_index;
    logic                 hit;
    logic                 victim_was_valid;
  } lookup_result_t;

  logic                       clk_i          = 1'b0;
  logic                       rst_ni         = 1'b0;
  logic                       in_valid_i     = 1'b0;
  logic                       in_ready_o;
  logic signed [KEY_W-1:0]    slot_x_i       = '0;
  logic signed [KEY_W-1:0]    slot_z_i       = '0;
  logic [STAMP_W-1:0]         frame_number_i = '0;
  logic                       out_valid_o;
  logic                       out_ready_i    = 1'b0;
  logic [OUT_IDX_W-1:0]       entry_index_o;
  logic                       hit_o;
  logic                       victim_was_valid_o;

  // shadow copy of the cache contents
  logic signed [KEY_W-1:0] cached_x [CACHE_ENTRIES] = '{default: '0};
  logic signed [KEY_W-1:0] cached_z [CACHE_ENTRIES] = '{default: '0};
  logic [STAMP_W-1:0]      last_use [CACHE_ENTRIES] = '{default: '0};
  bit                      occupied [CACHE_ENTRIES] = '{default: 1'b0};

  lookup_result_t pending_results[$];

  int unsigned error_count     = 0;
  int unsigned results_checked = 0;
  int unsigned queries_sent    = 0;
  int unsigned hit_count       = 0;
  int unsigned fill_count      = 0;
  int unsigned evict_count     = 0;
  int unsigned quiet_cycles    = 0;

  int unsigned burst_left       = 0;
  bit          gaps_enabled     = 1'b1;
  ready_mode_e ready_mode       = READY_RANDOM;
  int unsigned hold_off_request = 0;

  always #5 clk_i = ~clk_i;

  slot_cache_lru_lookup dut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_ready_o         (in_ready_o),
    .slot_x_i           (slot_x_i),
    .slot_z_i           (slot_z_i),
    .frame_number_i     (frame_number_i),
    .out_valid_o        (out_valid_o),
    .out_ready_i        (out_ready_i),
    .entry_index_o      (entry_index_o),
    .hit_o              (hit_o),
    .victim_was_valid_o (victim_was_valid_o)
  );

  function automatic lookup_result_t predict_lookup(input logic signed [KEY_W-1:0] qx,
                                                    input logic signed [KEY_W-1:0] qz,
                                                    input logic [STAMP_W-1:0] frame);
    lookup_result_t res;
    int unsigned    chosen;
    int unsigned    match_idx;
    int unsigned    free_idx;
    int unsigned    oldest_idx;
    bit             found;
    bit             have_free;
    bit             have_oldest;
    found       = 1'b0;
    have_free   = 1'b0;
    have_oldest = 1'b0;
    match_idx   = 0;
    free_idx    = 0;
    oldest_idx  = 0;
    for (int unsigned i = 0; i < CACHE_ENTRIES; i++) begin
      if (occupied[i]) begin
        if (!found && cached_x[i] == qx && cached_z[i] == qz) begin
          found     = 1'b1;
          match_idx = i;
        end
        // strict compare keeps the lowest index on equal stamps
        if (!have_oldest || last_use[i] < last_use[oldest_idx]) begin
          oldest_idx  = i;
          have_oldest = 1'b1;
        end
      end else if (!have_free) begin
        free_idx  = i;
        have_free = 1'b1;
      end
    end
    res.hit              = found;
    res.victim_was_valid = 1'b0;
    if (found) begin
      chosen = match_idx;
    end else begin
      if (have_free) begin
        chosen = free_idx;
      end else begin
        chosen               = oldest_idx;
        res.victim_was_valid = 1'b1;
      end
      cached_x[chosen] = qx;
      cached_z[chosen] = qz;
      occupied[chosen] = 1'b1;
    end
    last_use[chosen]  = frame;
    res.entry_index   = chosen[OUT_IDX_W-1:0];
    return res;
  endfunction

  task automatic send_query(input logic signed [KEY_W-1:0] qx,
                            input logic signed [KEY_W-1:0] qz,
                            input logic [STAMP_W-1:0] frame);
    int unsigned    gap;
    lookup_result_t expected_result;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 8);
      gap = 0;
      if (gaps_enabled) begin
        gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 90) : $urandom_range(0, 4);
      end
      if (gap != 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    slot_x_i       <= qx;
    slot_z_i       <= qz;
    frame_number_i <= frame;
    in_valid_i     <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    expected_result = predict_lookup(qx, qz, frame);
    pending_results = {pending_results, expected_result};
    queries_sent++;
    if (expected_result.hit) hit_count++;
    else if (expected_result.victim_was_valid) evict_count++;
    else fill_count++;
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic check_field(input string field, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, field, want, got);
      error_count++;
    end
  endtask

  // coordinate and stamp extremes, hits, near-miss keys and alternating bit patterns
  task automatic test_directed_extremes();
    send_query(16'sh0000, 16'sh0000, 32'h0000_0000);
    send_query(16'sh0000, 16'sh0000, 32'h0000_0005);
    send_query(16'sh8000, 16'sh8000, 32'hFFFF_FFFF);
    send_query(16'sh7FFF, 16'sh7FFF, 32'h0000_0001);
    send_query(16'sh8000, 16'sh7FFF, 32'h0000_0002);
    send_query(16'sh7FFF, 16'sh8000, 32'h0000_0003);
    send_query(16'shFFFF, 16'shFFFF, 32'h0000_0004);
    send_query(16'sh0001, 16'sh0001, 32'h0000_0004);
    send_query(16'sh0005, 16'sh0007, 32'h0000_0006);
    send_query(16'sh0005, 16'sh0008, 32'h0000_0006);
    send_query(16'sh0006, 16'sh0007, 32'h0000_0006);
    send_query(16'sh0005, 16'sh0007, 32'h0000_0007);
    send_query(16'sh8000, 16'sh8000, 32'h0000_0000);
    send_query(16'sh7FFF, 16'sh7FFF, 32'hFFFF_FFFF);
    send_query(16'sh5555, 16'shAAAA, 32'hAAAA_AAAA);
    send_query(16'shAAAA, 16'sh5555, 32'h5555_5555);
    send_query(16'sh0000, 16'sh0000, 32'h8000_0000);
    send_query(16'shFFFF, 16'shFFFF, 32'h7FFF_FFFF);
  endtask

  // send a new key for every entry, all with one shared stamp, then force evictions
  // on stamp ties and on stamps that went backwards
  task automatic test_fill_and_evict();
    for (int i = 0; i < CACHE_ENTRIES; i++) begin
      send_query(KEY_W'(1000 + i), KEY_W'(-1000 - i), 32'd100);
    end
    for (int i = 0; i < 8; i++) begin
      send_query(KEY_W'(3000 + i), KEY_W'(3000 + i), 32'd100);
    end
    for (int i = 0; i < 6; i++) begin
      send_query(KEY_W'(1000 + 10 * i), KEY_W'(-1000 - 10 * i), 32'd200);
    end
    for (int i = 0; i < 4; i++) begin
      send_query(KEY_W'(-5000 - i), KEY_W'(7), 32'd0);
    end
  endtask

  // receiver holds off while items keep coming, so the block backs up
  task automatic test_pressure();
    ready_mode       = READY_ALWAYS;
    gaps_enabled     = 1'b0;
    hold_off_request = HOLD_OFF_LEN;
    for (int i = 0; i < 12; i++) begin
      send_query(KEY_W'($urandom), KEY_W'($urandom), STAMP_W'($urandom));
    end
  endtask

  task automatic test_random_traffic(input int unsigned n_items);
    logic signed [KEY_W-1:0] pool_x [KEY_POOL];
    logic signed [KEY_W-1:0] pool_z [KEY_POOL];
    logic [STAMP_W-1:0]      frame_now;
    logic [STAMP_W-1:0]      qf;
    logic signed [KEY_W-1:0] qx;
    logic signed [KEY_W-1:0] qz;
    int unsigned             pick;
    int unsigned             roll;
    for (int i = 0; i < KEY_POOL; i++) begin
      pool_x[i] = KEY_W'($urandom);
      pool_z[i] = KEY_W'($urandom);
    end
    frame_now = $urandom_range(0, 1000);
    for (int unsigned n = 0; n < n_items; n++) begin
      // opening stretch runs with no idling on either side
      if (n == 0) begin
        gaps_enabled = 1'b0;
        ready_mode   = READY_ALWAYS;
      end else if (n >= n_items / 8 && n % 150 == 0) begin
        gaps_enabled = ($urandom_range(0, 3) != 0);
        ready_mode   = ready_mode_e'($urandom_range(0, 2));
      end
      // push stamps past the top so the counter wraps to small values
      if (n == n_items / 2) frame_now = 32'hFFFF_FFC0;
      roll = $urandom_range(0, 9);
      if (roll == 0) begin
        qx = KEY_W'($urandom);
        qz = KEY_W'($urandom);
      end else begin
        pick = (roll <= 6) ? $urandom_range(0, HOT_KEYS - 1) : $urandom_range(0, KEY_POOL - 1);
        qx   = pool_x[pick];
        qz   = pool_z[pick];
      end
      if ($urandom_range(0, 19) == 0) begin
        qf = STAMP_W'($urandom);
      end else begin
        frame_now = frame_now + $urandom_range(0, 3);
        qf        = frame_now;
      end
      send_query(qx, qz, qf);
    end
  endtask

  initial begin : receiver
    logic [15:0] ready_pattern;
    int unsigned pattern_phase;
    int unsigned pattern_age;
    int unsigned hold_cycles;
    ready_pattern = 16'hB3C5;
    pattern_phase = 0;
    pattern_age   = 0;
    forever begin
      @(posedge clk_i);
      if (hold_off_request != 0) begin
        hold_cycles      = hold_off_request;
        hold_off_request = 0;
        out_ready_i <= 1'b0;
        repeat (hold_cycles) @(posedge clk_i);
      end else begin
        case (ready_mode)
          READY_ALWAYS: begin
            out_ready_i <= 1'b1;
          end
          READY_RANDOM: begin
            out_ready_i <= ($urandom_range(0, 2) != 0);
          end
          default: begin
            out_ready_i   <= ready_pattern[pattern_phase];
            pattern_phase  = (pattern_phase + 1) % 16;
            pattern_age++;
            if (pattern_age == 256) begin
              pattern_age   = 0;
              ready_pattern = 16'($urandom) | 16'h0001;
            end
          end
        endcase
      end
    end
  end

  always @(posedge clk_i) begin : result_checker
    lookup_result_t expected_result;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, entry_index %0d hit %0b victim_was_valid %0b",
                 $time, entry_index_o, hit_o, victim_was_valid_o);
        error_count++;
      end else begin
        expected_result = pending_results.pop_front();
        check_field("entry_index", 32'(expected_result.entry_index), 32'(entry_index_o));
        check_field("hit", 32'(expected_result.hit), 32'(hit_o));
        check_field("victim_was_valid", 32'(expected_result.victim_was_valid),
                    32'(victim_was_valid_o));
        results_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("slot_cache_lru_lookup test failed");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_extremes();
    wait_for_results();
    test_fill_and_evict();
    wait_for_results();
    test_pressure();
    test_random_traffic(1080);
    wait_for_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("run covered %0d queries: %0d hits, %0d fills of free entries, %0d evictions",
             queries_sent, hit_count, fill_count, evict_count);
    $display("%0d results checked, %0d mismatches", results_checked, error_count);
    if (error_count == 0) begin
      $display("slot_cache_lru_lookup test passed");
    end else begin
      $display("slot_cache_lru_lookup test failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/scl_pkg.sv
hw/rtl/scl_ctrl.sv
hw/rtl/scl_dpath.sv
hw/rtl/slot_cache_lru_lookup.sv
verif/testbench.sv
